@@ src/spq_pkg.sv @@
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;
  localparam int INFO_W = 32;
  localparam int PRIO_W = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [INFO_W-1:0] info;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell of the chain in a cycle
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [PRIO_W-1:0] key;
  } cell_ctrl_t;

endpackage

@@ src/spq_cell.sv @@
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               left_le,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  input  spq_pkg::entry_t    new_entry,
  output logic               le,
  output spq_pkg::entry_t    entry
);

  // This slot stays ahead of the new entry: occupied and not greater than the key.
  assign le = occupied && (entry.prio <= ctrl.key);

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (!left_le) begin
        entry <= left_entry;
      end else if (!le) begin
        entry <= new_entry;
      end
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

@@ src/sorted_priority_queue.sv @@
// Channel   Direction  Handshake            Beat contents
// -------   ---------  -------------------  -------------------------------------------
// input     in         in_valid / in_ready  op, info, priority_req
// output    out        out_valid/out_ready  status, out_info, out_priority, occupancy
//
// One beat in, one beat out; each result is registered and shows in the cycle
// after its beat is taken. A new input beat can be taken every cycle, as the
// whole cell chain compares and shifts at once; the rate is set by the output
// register: input stalls only while it holds a beat that is not taken. Reset
// (rst, synchronous) empties the queue at once by clearing the fill count; slot contents are not cleared.
module sorted_priority_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic signed [spq_pkg::INFO_W-1:0]     info,
  input  logic signed [spq_pkg::PRIO_W-1:0]     priority_req,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output spq_pkg::status_t                      status,
  output logic signed [spq_pkg::INFO_W-1:0]     out_info,
  output logic signed [spq_pkg::PRIO_W-1:0]     out_priority,
  output logic [spq_pkg::OCC_W-1:0]             occupancy
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_ctrl_t       ctrl;
  spq_pkg::entry_t           new_entry;
  spq_pkg::entry_t           cells [spq_pkg::DEPTH];
  logic                      le [spq_pkg::DEPTH];
  logic                      occupied [spq_pkg::DEPTH];

  // Take a beat whenever the output register is free or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty    = (count == '0);

  assign new_entry.info = info;
  assign new_entry.prio = priority_req;

  // Refused operations leave every cell alone.
  assign ctrl.enq = accept && (op == spq_pkg::OP_ENQ) && !full;
  assign ctrl.deq = accept && (op == spq_pkg::OP_DEQ) && !empty;
  assign ctrl.key = priority_req;

  // Build the chain: each cell looks left on insert and right on removal.
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    assign occupied[i] = (spq_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_le     (1'b1),
        .left_entry  (new_entry),
        .right_entry (cells[i+1]),
        .new_entry   (new_entry),
        .le          (le[i]),
        .entry       (cells[i])
      );
    end else if (i == spq_pkg::DEPTH - 1) begin : g_tail
      // Nothing lies beyond the tail; on removal it keeps a stale copy.
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_le     (le[i-1]),
        .left_entry  (cells[i-1]),
        .right_entry (cells[i]),
        .new_entry   (new_entry),
        .le          (le[i]),
        .entry       (cells[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_le     (le[i-1]),
        .left_entry  (cells[i-1]),
        .right_entry (cells[i+1]),
        .new_entry   (new_entry),
        .le          (le[i]),
        .entry       (cells[i])
      );
    end
  end

  // Advance the fill count.
  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + 1'b1;
    end else if (ctrl.deq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register: hold the beat until taken, load on every accepted input.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= spq_pkg::OCC_W'(count_next);
      if (op == spq_pkg::OP_ENQ) begin
        status       <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        out_info     <= '0;
        out_priority <= '0;
      end else if (empty) begin
        status       <= spq_pkg::ST_EMPTY;
        out_info     <= '1;
        out_priority <= '1;
      end else begin
        status       <= spq_pkg::ST_OK;
        out_info     <= cells[0].info;
        out_priority <= cells[0].prio;
      end
    end
  end

  // Fill count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("fill count beyond capacity");

  // The two front slots stay in order.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |-> (cells[0].prio <= cells[1].prio))
    else $error("head slots out of order");

  // A removal from a non-empty queue reports ok and drops the count by one.
  a_deq_ok: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == spq_pkg::OP_DEQ) && !empty) |=>
      (out_valid && (status == spq_pkg::ST_OK) && (count == $past(count) - 1'b1)))
    else $error("dequeue result mismatch");

  // An insert into a full queue is refused and changes nothing.
  a_enq_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == spq_pkg::OP_ENQ) && full) |=>
      ((status == spq_pkg::ST_FULL) && (count == spq_pkg::CNT_W'(spq_pkg::DEPTH))))
    else $error("full insert not refused");

endmodule
